FILE: sv/qbsh_pkg.sv
package qbsh_pkg;

  // default coordinate width, signed fixed point with 8 fraction bits
  localparam int COORD_BITS_DEF  = 24;
  // default number of fraction bits of a reported root
  localparam int T_FRAC_BITS_DEF = 16;
  // width of the hit count field
  localparam int COUNT_BITS      = 2;

  localparam logic [COUNT_BITS-1:0] HITS_NONE = 2'd0;
  localparam logic [COUNT_BITS-1:0] HITS_ONE  = 2'd1;
  localparam logic [COUNT_BITS-1:0] HITS_TWO  = 2'd2;

endpackage

FILE: sv/qbsh_if.sv
interface qbsh_in_if
  import qbsh_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] p0_y;
  logic signed [CB-1:0] p1_y;
  logic signed [CB-1:0] p2_y;
  logic signed [CB-1:0] line_y;

  modport source (output valid, p0_y, p1_y, p2_y, line_y, input ready);
  modport sink   (input valid, p0_y, p1_y, p2_y, line_y, output ready);
endinterface

interface qbsh_out_if
  import qbsh_pkg::*;
#(
  parameter int TF = T_FRAC_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] hit_count;
  logic [TF:0]           first_t;
  logic [TF:0]           second_t;

  modport source (output valid, hit_count, first_t, second_t, input ready);
  modport sink   (input valid, hit_count, first_t, second_t, output ready);
endinterface

FILE: sv/quadratic_bezier_scanline_hit.sv
// Scanline hit test for a quadratic Bezier curve. Each item carries the y of the three
// control points and the scanline height (signed, 8 fraction bits); the result item gives
// how many curve parameters t in [0,1] meet the line (0..2) and those roots as unsigned
// fractions with T_FRAC_BITS fraction bits, truncated, where 2^T_FRAC_BITS means 1.0.
// The root of the quadratic form comes first when in range; unused root fields read zero.
// A new item is taken every clock unless the output register holds an item that is not taken.
// The pipe holds the bit-per-stage square root (COORD_BITS + 2 stages) and the two
// bit-per-stage dividers (T_FRAC_BITS + 1 stages) that follow it.
// The whole pipe advances together whenever the output register is empty or being taken.
module quadratic_bezier_scanline_hit
  import qbsh_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  qbsh_in_if.sink   in_ch,
  qbsh_out_if.source out_ch
);

  // widths of the intermediate values
  localparam int AW   = COORD_BITS + 3;      // signed a, b, c
  localparam int MW   = COORD_BITS + 2;      // magnitudes of a, b, c
  localparam int RW   = 2 * MW;              // discriminant
  localparam int SW   = MW;                  // integer square root
  localparam int REMW = SW + 4;              // square root remainder
  localparam int QW   = COORD_BITS + 4;      // signed q = b +/- s
  localparam int DW   = COORD_BITS + 3;      // divider operand magnitudes
  localparam int TW   = T_FRAC_BITS + 1;     // root field

  typedef struct packed {
    logic                 neg;    // negative discriminant, no hits
    logic                 rzero;  // tangent, single candidate
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
  } ctx_t;

  typedef struct packed {
    logic          neg;
    logic          ok0;
    logic          ok1;
    logic [DW-1:0] ud0;
    logic [DW-1:0] ud1;
  } dctx_t;

  // global advance: the output register is free or its item is being taken
  logic en;
  logic out_v_r;
  assign en           = !out_v_r || out_ch.ready;
  assign in_ch.ready  = en;

  // ---------------------------------------------------------------- stage 1: a, b, c
  logic                 v1_r;
  logic signed [AW-1:0] a1_r, b1_r, c1_r;
  logic signed [AW-1:0] p0x, p1x, p2x, lyx;

  assign p0x = AW'(in_ch.p0_y);
  assign p1x = AW'(in_ch.p1_y);
  assign p2x = AW'(in_ch.p2_y);
  assign lyx = AW'(in_ch.line_y);

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= p0x - (p1x <<< 1) + p2x;
      b1_r <= (p1x <<< 1) - (p0x <<< 1);
      c1_r <= p0x - lyx;
    end
  end

  // ---------------------------------------------------------------- stage 2: b*b and 4ac
  logic                 v2_r;
  logic [RW-1:0]        bb2_r, fac2_r;
  logic                 add2_r;
  logic signed [AW-1:0] a2_r, b2_r, c2_r;
  logic [MW-1:0]        ma1, mb1, mc1;
  logic [RW-1:0]        ac1;

  assign ma1 = MW'(a1_r < 0 ? -a1_r : a1_r);
  assign mb1 = MW'(b1_r < 0 ? -b1_r : b1_r);
  assign mc1 = MW'(c1_r < 0 ? -c1_r : c1_r);
  assign ac1 = ma1 * mc1;

  always_ff @(posedge clk) begin
    if (en) begin
      bb2_r  <= mb1 * mb1;
      fac2_r <= {ac1[RW-3:0], 2'b00};
      // opposite signs or a zero term: the discriminant is a sum of magnitudes
      add2_r <= ((a1_r < 0) != (c1_r < 0)) || (a1_r == '0) || (c1_r == '0);
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: discriminant
  logic          v3_r;
  logic [RW-1:0] r3_r;
  ctx_t          ctx3_r;
  logic [RW-1:0] r2;

  assign r2 = add2_r ? bb2_r + fac2_r : bb2_r - fac2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_r         <= r2;
      ctx3_r.neg   <= !add2_r && (bb2_r < fac2_r);
      ctx3_r.rzero <= (r2 == '0);
      ctx3_r.a     <= a2_r;
      ctx3_r.b     <= b2_r;
      ctx3_r.c     <= c2_r;
    end
  end

  // ---------------------------------------------------------------- square root, one bit a stage
  logic            sq_v_r    [SW+1];
  logic [RW-1:0]   sq_rad_r  [SW+1];
  logic [REMW-1:0] sq_rem_r  [SW+1];
  logic [SW-1:0]   sq_root_r [SW+1];
  ctx_t            sq_ctx_r  [SW+1];

  assign sq_v_r[0]    = v3_r;
  assign sq_rad_r[0]  = r3_r;
  assign sq_rem_r[0]  = '0;
  assign sq_root_r[0] = '0;
  assign sq_ctx_r[0]  = ctx3_r;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            take;

    assign rem_sh = {sq_rem_r[i][REMW-3:0], sq_rad_r[i][RW-1 -: 2]};
    assign trial  = {2'b00, sq_root_r[i], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[i+1]  <= sq_rad_r[i] << 2;
        sq_rem_r[i+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root_r[i+1] <= {sq_root_r[i][SW-2:0], take};
        sq_ctx_r[i+1]  <= sq_ctx_r[i];
      end
    end
  end

  // ---------------------------------------------------------------- q = b +/- s
  logic                 vq_r;
  logic signed [QW-1:0] q_r;
  ctx_t                 ctxq_r;
  logic signed [QW-1:0] bq, sq;

  assign bq = QW'(sq_ctx_r[SW].b);
  assign sq = QW'({1'b0, sq_root_r[SW]});

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= (bq >= 0) ? bq + sq : bq - sq;
      ctxq_r <= sq_ctx_r[SW];
    end
  end

  // ---------------------------------------------------------------- range checks
  logic                 vc_r;
  logic [DW-1:0]        un0_r, un1_r;
  dctx_t                dctxc_r;
  logic signed [QW-1:0] num0, den0, num1, den1;
  logic [QW-1:0]        mn0, md0, mn1, md1;
  logic                 ok0c, ok1c;

  assign num0 = -q_r;
  assign den0 = QW'(ctxq_r.a) <<< 1;
  assign num1 = -(QW'(ctxq_r.c) <<< 1);
  assign den1 = q_r;
  assign mn0  = num0 < 0 ? -num0 : num0;
  assign md0  = den0 < 0 ? -den0 : den0;
  assign mn1  = num1 < 0 ? -num1 : num1;
  assign md1  = den1 < 0 ? -den1 : den1;
  // zero divisor, wrong sign or quotient above one all count as out of range
  assign ok0c = (den0 != '0) && !((num0 != '0) && ((num0 < 0) != (den0 < 0))) && (mn0 <= md0);
  assign ok1c = (den1 != '0) && !((num1 != '0) && ((num1 < 0) != (den1 < 0))) && (mn1 <= md1)
                && !ctxq_r.rzero;

  always_ff @(posedge clk) begin
    if (en) begin
      un0_r       <= DW'(mn0);
      un1_r       <= DW'(mn1);
      dctxc_r.neg <= ctxq_r.neg;
      dctxc_r.ok0 <= ok0c;
      dctxc_r.ok1 <= ok1c;
      dctxc_r.ud0 <= DW'(md0);
      dctxc_r.ud1 <= DW'(md1);
    end
  end

  // ---------------------------------------------------------------- two dividers, one bit a stage
  logic          dv_v_r    [TW+1];
  logic [DW-1:0] dv_rem0_r [TW+1];
  logic [DW-1:0] dv_rem1_r [TW+1];
  logic [TW-1:0] dv_quo0_r [TW+1];
  logic [TW-1:0] dv_quo1_r [TW+1];
  dctx_t         dv_ctx_r  [TW+1];

  assign dv_v_r[0]    = vc_r;
  assign dv_rem0_r[0] = un0_r;
  assign dv_rem1_r[0] = un1_r;
  assign dv_quo0_r[0] = '0;
  assign dv_quo1_r[0] = '0;
  assign dv_ctx_r[0]  = dctxc_r;

  for (genvar j = 0; j < TW; j++) begin : g_div
    logic [DW:0] sh0, sh1;
    logic        ge0, ge1;

    // the first step takes the integer bit, so no shift there
    assign sh0 = (j == 0) ? {1'b0, dv_rem0_r[j]} : {dv_rem0_r[j], 1'b0};
    assign sh1 = (j == 0) ? {1'b0, dv_rem1_r[j]} : {dv_rem1_r[j], 1'b0};
    assign ge0 = sh0 >= {1'b0, dv_ctx_r[j].ud0};
    assign ge1 = sh1 >= {1'b0, dv_ctx_r[j].ud1};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem0_r[j+1] <= DW'(ge0 ? sh0 - {1'b0, dv_ctx_r[j].ud0} : sh0);
        dv_rem1_r[j+1] <= DW'(ge1 ? sh1 - {1'b0, dv_ctx_r[j].ud1} : sh1);
        dv_quo0_r[j+1] <= {dv_quo0_r[j][TW-2:0], ge0};
        dv_quo1_r[j+1] <= {dv_quo1_r[j][TW-2:0], ge1};
        dv_ctx_r[j+1]  <= dv_ctx_r[j];
      end
    end
  end

  // ---------------------------------------------------------------- result ordering, output register
  logic [COUNT_BITS-1:0] cnt_nxt, cnt_r;
  logic [TW-1:0]         first_nxt, second_nxt, first_r, second_r;
  dctx_t                 fin;

  assign fin = dv_ctx_r[TW];

  always_comb begin
    cnt_nxt    = HITS_NONE;
    first_nxt  = '0;
    second_nxt = '0;
    if (!fin.neg) begin
      if (fin.ok0) begin
        first_nxt = dv_quo0_r[TW];
        cnt_nxt   = HITS_ONE;
        if (fin.ok1) begin
          second_nxt = dv_quo1_r[TW];
          cnt_nxt    = HITS_TWO;
        end
      end else if (fin.ok1) begin
        first_nxt = dv_quo1_r[TW];
        cnt_nxt   = HITS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  // valid bits of the stages outside the square root and dividers, and of the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vq_r    <= 1'b0;
      vc_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vq_r    <= sq_v_r[SW];
      vc_r    <= vq_r;
      out_v_r <= dv_v_r[TW];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.hit_count = cnt_r;
  assign out_ch.first_t   = first_r;
  assign out_ch.second_t  = second_r;

endmodule

FILE: sv/qbsh_checker.sv
module qbsh_checker
  import qbsh_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_BITS-1:0] hit_count,
  input logic [T_FRAC_BITS:0]  first_t,
  input logic [T_FRAC_BITS:0]  second_t
);

  localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

  // a stalled result item holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit_count) && $stable(first_t)
                                && $stable(second_t))
    else $error("result item changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hit_count == HITS_NONE || hit_count == HITS_ONE || hit_count == HITS_TWO)
    else $error("hit count out of range");

  // unused root fields read zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit_count != HITS_TWO |-> second_t == '0 &&
      (hit_count != HITS_NONE || first_t == '0))
    else $error("unused root field not zero");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> first_t <= T_ONE && second_t <= T_ONE)
    else $error("root above one");

endmodule

bind quadratic_bezier_scanline_hit qbsh_checker #(
  .T_FRAC_BITS (T_FRAC_BITS)
) u_qbsh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit_count (out_ch.hit_count),
  .first_t   (out_ch.first_t),
  .second_t  (out_ch.second_t)
);
